>>> sv/rpsc_pkg.sv
// Shared types, widths, register codes and constants of the ramped PWM speed controller.
package rpsc_pkg;

  localparam int unsigned SpeedW = 14;
  localparam int unsigned DutyW  = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 2;

  // Divide by 10 as a multiply by a reciprocal and a shift; exact for magnitudes below 2**14.
  localparam int unsigned Divisor   = 10;
  localparam int unsigned Div10Shift = 16;
  localparam int unsigned Div10Mul  = (1 << Div10Shift) / Divisor + 1;
  localparam int unsigned Div10MulW = 13;
  localparam int unsigned ErrW      = SpeedW + 1;
  localparam int unsigned ErrMagW   = SpeedW;
  localparam int unsigned ProdW     = ErrMagW + Div10MulW;
  localparam int unsigned QuoW      = ProdW - Div10Shift;

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic        [DutyW-1:0]  duty_t;
  typedef logic        [CfgW-1:0]   cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_LIMIT = 2'd0,
    CFG_DECEL_STEP = 2'd1,
    CFG_DUTY_LIMIT = 2'd2
  } cfg_idx_e;

  localparam cfg_data_t StepLimitRst = 12'd20;
  localparam cfg_data_t DecelStepRst = 12'd20;
  localparam cfg_data_t DutyLimitRst = 12'd900;

endpackage

>>> sv/rpsc_in_if.sv
// Request channel carrying one speed setpoint and one measured speed per control tick.
interface rpsc_in_if import rpsc_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t setpoint;
  speed_t measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

>>> sv/rpsc_out_if.sv
// Result channel carrying the PWM duty and drive direction after each control tick.
interface rpsc_out_if import rpsc_pkg::*; ();
  logic  valid;
  logic  ready;
  duty_t duty;
  logic  direction;

  modport source (output valid, output duty, output direction, input ready);
  modport sink   (input valid, input duty, input direction, output ready);
endinterface

>>> sv/ramped_pwm_speed_controller.sv
// Top level of the ramped PWM speed controller: integral velocity loop with reversal ramp.
//
// Usage:
//   req_i carries one request per control tick: a signed setpoint and a measured
//   speed. rsp_o returns exactly one result per request: the new PWM duty and the
//   drive direction (1 forward, 0 reverse), in request order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write step_limit (0), decel_step (1) and
//   duty_limit (2); other indexes are ignored. Write only while the block is idle.
// Pipeline:
//   Three registered stages: request register, step stage (setpoint clamp,
//   error divided by 10, step clamp) and the duty/direction state, which is
//   also the result register. An accepted request moves from the request
//   register through the step register into the state register, which drives
//   rsp_o.valid; one request is accepted every cycle while rsp_o is drained.
//   The duty update needs only the previous duty and direction.
// Reset:
//   rst_ni clears every stage's valid flag, sets duty to 0 and direction to reverse, and
//   loads the register defaults (20, 20, 900). No clearing pass is needed.
// Stall:
//   When rsp_o is held off, the result stays put and the stages fill; req_i
//   drops ready only once every stage holds a request.
module ramped_pwm_speed_controller import rpsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rpsc_in_if.sink              req_i,
  rpsc_out_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  cfg_data_t            cfg_data_i
);

  // Configuration registers.
  cfg_data_t step_limit_q, decel_step_q, duty_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= StepLimitRst;
      decel_step_q <= DecelStepRst;
      duty_limit_q <= DutyLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_LIMIT: step_limit_q <= cfg_data_i;
        CFG_DECEL_STEP: decel_step_q <= cfg_data_i;
        CFG_DUTY_LIMIT: duty_limit_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage handshakes: a stage takes a new request when empty or when it hands on.
  logic a_vld_q, b_vld_q, c_vld_q;
  logic a_ready, b_ready, c_ready;
  logic a_fire, b_fire;

  assign c_ready = !c_vld_q || rsp_o.ready;
  assign b_ready = !b_vld_q || c_ready;
  assign a_ready = !a_vld_q || b_ready;
  assign a_fire  = a_vld_q && b_ready;
  assign b_fire  = b_vld_q && c_ready;

  assign req_i.ready = a_ready;

  // Stage A: request register.
  speed_t a_sp_q, a_pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_ready) begin
      a_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && req_i.valid) begin
      a_sp_q <= req_i.setpoint;
      a_pv_q <= req_i.measured;
    end
  end

  // Step computation: clamp the setpoint magnitude, divide the error by 10
  // toward zero, then clamp the step magnitude to step_limit.
  logic [SpeedW-1:0]        sp_mag;
  duty_t                    sp_clip;
  logic                     tdir;
  logic signed [ErrW-1:0]   err;
  logic                     err_neg;
  logic [ErrMagW-1:0]       err_mag;
  logic [ProdW-1:0]         prod;
  logic [QuoW-1:0]          quo;
  logic [QuoW-1:0]          step_mag;

  always_comb begin
    sp_mag  = a_sp_q[SpeedW-1] ? SpeedW'(~a_sp_q + 1'b1) : SpeedW'(a_sp_q);
    sp_clip = (sp_mag > SpeedW'(duty_limit_q)) ? duty_limit_q : sp_mag[DutyW-1:0];
    tdir    = !a_sp_q[SpeedW-1] && (a_sp_q != '0);
    err     = $signed({{(ErrW-DutyW){1'b0}}, sp_clip})
              - $signed({a_pv_q[SpeedW-1], a_pv_q});
    err_neg = err[ErrW-1];
    err_mag = err_neg ? ErrMagW'(-err) : err[ErrMagW-1:0];
    prod    = ProdW'(err_mag) * ProdW'(Div10Mul);
    quo     = prod[ProdW-1:Div10Shift];
    step_mag = (CfgW'(quo) > step_limit_q) ? step_limit_q[QuoW-1:0] : quo;
  end

  // Stage B: step register.
  duty_t           b_mag_q;
  logic            b_tdir_q;
  logic            b_neg_q;
  logic [QuoW-1:0] b_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_mag_q  <= sp_clip;
      b_tdir_q <= tdir;
      b_neg_q  <= err_neg && (step_mag != '0);
      b_step_q <= step_mag;
    end
  end

  // Duty update against the stored state.
  duty_t             duty_q, duty_d;
  logic              dir_q, dir_d;
  logic [DutyW:0]    run;
  duty_t             clipped;

  always_comb begin
    dir_d = dir_q;
    run   = {1'b0, duty_q};
    if (b_mag_q != '0) begin
      if (dir_q != b_tdir_q) begin
        // Ramp down toward the reversal; flip once the duty reaches zero.
        if (duty_q > decel_step_q) begin
          run = {1'b0, duty_q - decel_step_q};
        end else begin
          run   = '0;
          dir_d = b_tdir_q;
        end
      end else if (b_neg_q) begin
        run = (duty_q > DutyW'(b_step_q)) ? {1'b0, duty_q - DutyW'(b_step_q)} : '0;
      end else begin
        run = {1'b0, duty_q} + (DutyW+1)'(b_step_q);
      end
    end
    clipped = (run > {1'b0, duty_limit_q}) ? duty_limit_q : run[DutyW-1:0];
    if (b_mag_q == '0) begin
      // Stop: ramp down by the decel step, hold the direction.
      duty_d = (clipped > decel_step_q) ? clipped - decel_step_q : '0;
    end else begin
      duty_d = clipped;
    end
  end

  // Stage C: state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      duty_q  <= '0;
      dir_q   <= 1'b0;
    end else begin
      if (c_ready) begin
        c_vld_q <= b_vld_q;
      end
      if (b_fire) begin
        duty_q <= duty_d;
        dir_q  <= dir_d;
      end
    end
  end

  assign rsp_o.valid     = c_vld_q;
  assign rsp_o.duty      = duty_q;
  assign rsp_o.direction = dir_q;

endmodule
